// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the ROM search engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OWRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define OWRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OWRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define OWRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/owrs_pkg.sv =====
// Types, codes and helper functions of the ROM search engine.
`default_nettype none
package owrs_pkg;

  localparam int CODE_BITS = 64;
  localparam int IDX_W     = $clog2(CODE_BITS);
  localparam int ROM_W     = 64;
  localparam int CNT_W     = 8;
  localparam int CRC_W     = 8;
  localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;
  localparam logic [CNT_W-1:0] MAX_DEV_RESET = 8'd8;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CODE_BITS - 1);

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_RESET = 2'd1,
    REQ_BIT   = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_DIRECTION   = 3'd1,
    ST_FOUND       = 3'd2,
    ST_NO_PRESENCE = 3'd3,
    ST_BUS_ERROR   = 3'd4,
    ST_CRC_ERROR   = 3'd5,
    ST_OUT_OF_SEQ  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_READY = 3'b010,
    PH_PASS  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       presence;
    logic       id_bit;
    logic       inv_bit;
  } owrs_req_t;

  typedef struct packed {
    status_t          status;
    logic             send_bit;
    logic [ROM_W-1:0] rom_code;
    logic [CNT_W-1:0] device_number;
    logic             search_finished;
  } owrs_rsp_t;

  // Control state of the search; the assembled code is kept apart.
  typedef struct packed {
    phase_t           phase;
    logic             lb_vld;
    logic [IDX_W-1:0] lb_idx;
    logic             lzb_vld;
    logic [IDX_W-1:0] lzb_idx;
    logic [IDX_W-1:0] pos;
    logic [CRC_W-1:0] crc;
    logic [CNT_W-1:0] found;
  } owrs_state_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic bit_in);
    logic [CRC_W-1:0] shifted;
    shifted = crc >> 1;
    return (crc[0] ^ bit_in) ? (shifted ^ CRC_POLY) : shifted;
  endfunction

endpackage
`default_nettype wire

// ===== src/owrs_step.sv =====
// Next-state and result logic of the ROM search engine for one request.
`default_nettype none
module owrs_step (
  input  owrs_pkg::owrs_state_t                 cur,
  input  logic [owrs_pkg::CODE_BITS-1:0]        code,
  input  owrs_pkg::owrs_req_t                   req,
  input  logic [owrs_pkg::CNT_W-1:0]            max_dev,
  output owrs_pkg::owrs_state_t                 nxt,
  output logic [owrs_pkg::CODE_BITS-1:0]        code_nxt,
  output owrs_pkg::owrs_rsp_t                   rsp
);
  import owrs_pkg::*;

  logic             dir;
  logic             lzb_vld_new;
  logic [IDX_W-1:0] lzb_idx_new;
  logic [CRC_W-1:0] crc_new;
  logic [CNT_W-1:0] found_new;
  logic             done;

  // Direction choice from the last-discrepancy rules.
  always_comb begin
    dir         = req.id_bit;
    lzb_vld_new = cur.lzb_vld;
    lzb_idx_new = cur.lzb_idx;
    if (!req.id_bit && !req.inv_bit) begin
      if (cur.lb_vld && (cur.pos == cur.lb_idx)) begin
        dir = 1'b1;
      end else if (!cur.lb_vld || (cur.pos > cur.lb_idx)) begin
        dir = 1'b0;
      end else begin
        dir = code[cur.pos];
      end
      if (!dir) begin
        lzb_vld_new = 1'b1;
        lzb_idx_new = cur.pos;
      end
    end
  end

  assign crc_new   = crc_step(cur.crc, dir);
  assign found_new = cur.found + CNT_W'(1);
  assign done      = !lzb_vld_new || (found_new >= max_dev);

  always_comb begin
    nxt      = cur;
    code_nxt = code;
    rsp      = '{status: ST_OUT_OF_SEQ, send_bit: 1'b0, rom_code: '0,
                 device_number: cur.found, search_finished: 1'b0};
    case (req.req_type)
      REQ_BEGIN: begin
        nxt.phase         = PH_READY;
        nxt.lb_vld        = 1'b0;
        nxt.lzb_vld       = 1'b0;
        nxt.pos           = '0;
        nxt.crc           = '0;
        nxt.found         = '0;
        code_nxt          = '0;
        rsp.status        = ST_ACCEPTED;
        rsp.device_number = '0;
      end
      REQ_RESET: begin
        if (cur.phase == PH_READY) begin
          if (!req.presence) begin
            nxt.phase = PH_IDLE;
            if (cur.found != '0) begin
              rsp.status          = ST_ACCEPTED;
              rsp.search_finished = 1'b1;
            end else begin
              rsp.status = ST_NO_PRESENCE;
            end
          end else begin
            nxt.phase   = PH_PASS;
            nxt.pos     = '0;
            nxt.lzb_vld = 1'b0;
            nxt.crc     = '0;
            rsp.status  = ST_ACCEPTED;
          end
        end
      end
      REQ_BIT: begin
        if (cur.phase == PH_PASS) begin
          if (req.id_bit && req.inv_bit) begin
            nxt.phase  = PH_IDLE;
            rsp.status = ST_BUS_ERROR;
          end else begin
            code_nxt[cur.pos] = dir;
            nxt.lzb_vld       = lzb_vld_new;
            nxt.lzb_idx       = lzb_idx_new;
            nxt.crc           = crc_new;
            nxt.pos           = cur.pos + IDX_W'(1);
            rsp.send_bit      = dir;
            if (cur.pos != LAST_POS) begin
              rsp.status = ST_DIRECTION;
            end else if (crc_new != '0) begin
              nxt.phase  = PH_IDLE;
              rsp.status = ST_CRC_ERROR;
            end else begin
              nxt.found           = found_new;
              nxt.lb_vld          = lzb_vld_new;
              nxt.lb_idx          = lzb_idx_new;
              nxt.phase           = done ? PH_IDLE : PH_READY;
              rsp.status          = ST_FOUND;
              rsp.rom_code        = ROM_W'(code_nxt);
              rsp.device_number   = found_new;
              rsp.search_finished = done;
            end
          end
        end
      end
      default: begin
        rsp.status = ST_OUT_OF_SEQ;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/onewire_rom_search.sv =====
// Top level of the single-wire bus ROM search engine.
//
//   Channel   Direction  Handshake          Payload
//   in_       inbound    in_valid/in_stall  owrs_req_t (req_type, presence, bit pair)
//   out_      outbound   out_valid/out_stall owrs_rsp_t (status, send_bit, code, count)
//   cfg_      inbound    cfg_valid/cfg_ready cfg_data: max_devices
//
// Every request yields exactly one response, which passes through the request register
// and then the response register before it can be taken.
// A new request is taken in every cycle while in_stall is low; throughput is one
// request per cycle, set by the combinational state update in the step logic.
// Reset (rst_n low, synchronous) clears the search to idle and max_devices to 8.
// A stalled output holds its response; the request register then holds too and
// in_stall rises, so nothing is lost or repeated.
`default_nettype none
module onewire_rom_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  owrs_pkg::owrs_req_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output owrs_pkg::owrs_rsp_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [owrs_pkg::CNT_W-1:0]  cfg_data
);
  import owrs_pkg::*;

`include "assert_macros.svh"

  // Request register: the first stage of the two-stage pipeline.
  logic                 in_vld_r, in_vld_nxt;
  owrs_req_t            in_req_r;

  // Search state. The code register is payload and has no reset.
  owrs_state_t          st_r, st_nxt;
  logic [CODE_BITS-1:0] code_r, code_nxt;

  // Response register.
  logic                 out_vld_r, out_vld_nxt;
  owrs_rsp_t            out_rsp_r, rsp;

  logic [CNT_W-1:0]     max_dev_r;

  logic                 advance;
  logic                 fire;
  logic                 in_acc;

  // The response register can take a new value when empty or being drained.
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  assign in_vld_nxt  = (in_vld_r && !fire) || in_acc;
  assign out_vld_nxt = fire || (out_vld_r && out_stall);

  // The register accepts writes at any time; the user writes it only when idle.
  assign cfg_ready = 1'b1;

  owrs_step u_step (
    .cur      (st_r),
    .code     (code_r),
    .req      (in_req_r),
    .max_dev  (max_dev_r),
    .nxt      (st_nxt),
    .code_nxt (code_nxt),
    .rsp      (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      max_dev_r <= MAX_DEV_RESET;
      st_r      <= '{phase: PH_IDLE, lb_vld: 1'b0, lb_idx: '0, lzb_vld: 1'b0,
                     lzb_idx: '0, pos: '0, crc: '0, found: '0};
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        max_dev_r <= cfg_data;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_req_r <= in_data;
    end
    if (fire) begin
      code_r    <= code_nxt;
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_rsp_r;

  // A processed request always lands in the response register.
  `OWRS_ASSERT_NEXT(a_fire_to_out, clk, rst_n, fire, out_vld_r,
    "processed request did not produce a response")
  // Finding a device advances the device count by exactly one.
  `OWRS_ASSERT_NEXT(a_found_count, clk, rst_n, fire && (rsp.status == ST_FOUND),
    st_r.found == CNT_W'($past(st_r.found) + CNT_W'(1)), "device count did not advance")
  // A direction response moves to the next bit of the pass.
  `OWRS_ASSERT_NEXT(a_dir_pos, clk, rst_n, fire && (rsp.status == ST_DIRECTION),
    st_r.pos == IDX_W'($past(st_r.pos) + IDX_W'(1)), "bit position did not advance")
  // A finished search leaves the engine idle.
  `OWRS_ASSERT_NEXT(a_finish_idle, clk, rst_n, fire && rsp.search_finished,
    st_r.phase == PH_IDLE, "engine not idle after the search finished")

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for the ROM search engine: table-driven bring-up, then simulated device buses.
`timescale 1ns / 1ps
module tb_top;
  import owrs_pkg::*;

  // The package names only three request kinds; the fourth encoding must be refused.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_BUS_DEVICES = 8;
  localparam int ITEMS_PER_PHASE = 310;
  localparam int HOLD_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  owrs_req_t in_data;
  logic out_valid;
  logic out_stall;
  owrs_rsp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  onewire_rom_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Responses the engine still owes us, oldest first.
  owrs_rsp_t pending_rsp[$];
  int mismatches = 0;

  // Idling controls. A calm side never idles; hold_ask makes the receiver
  // refuse responses for a long stretch while the sender keeps pushing.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_ask = 1'b0;

  // Our own copy of the search state. Branch indexes use -1 for "none yet".
  logic [63:0]      sr_code;
  int               sr_last;
  int               sr_last_zero;
  int               sr_pos;
  logic [CRC_W-1:0] sr_crc;
  logic [CNT_W-1:0] sr_found;
  logic [CNT_W-1:0] sr_limit;
  phase_t           sr_phase;

  // The simulated bus: every device drives its code, and the search direction
  // written back drops the devices that disagree with it.
  logic [63:0]                dev_code [MAX_BUS_DEVICES];
  int                         dev_count;
  logic [MAX_BUS_DEVICES-1:0] alive;

  // Bit-serial CRC-8, reflected form: shift right and fold in the polynomial
  // whenever the outgoing bit differs from the incoming one.
  function automatic logic [CRC_W-1:0] crc8_shift(input logic [CRC_W-1:0] c, input logic b);
    logic fb;
    fb = c[0] ^ b;
    c = c >> 1;
    if (fb) begin
      c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Advances the search state by one request and returns the response the
  // engine has to give for it.
  function automatic owrs_rsp_t search_step(input owrs_req_t r);
    owrs_rsp_t o;
    logic      dir;
    logic      done;
    o = '0;
    o.status = ST_OUT_OF_SEQ;
    if (r.req_type == REQ_BEGIN) begin
      // A begin is honored in every phase and wipes the whole search.
      sr_code = '0;
      sr_last = -1;
      sr_last_zero = -1;
      sr_pos = 0;
      sr_crc = '0;
      sr_found = '0;
      sr_phase = PH_READY;
      o.status = ST_ACCEPTED;
    end else if (r.req_type == REQ_RESET && sr_phase == PH_READY) begin
      if (!r.presence) begin
        // Silence on the bus is a failure only if nothing was found so far;
        // otherwise it just means the search is over.
        sr_phase = PH_IDLE;
        if (sr_found != '0) begin
          o.status = ST_ACCEPTED;
          o.search_finished = 1'b1;
        end else begin
          o.status = ST_NO_PRESENCE;
        end
      end else begin
        sr_pos = 0;
        sr_last_zero = -1;
        sr_crc = '0;
        sr_phase = PH_PASS;
        o.status = ST_ACCEPTED;
      end
    end else if (r.req_type == REQ_BIT && sr_phase == PH_PASS) begin
      if (r.id_bit && r.inv_bit) begin
        // Nobody answered the slot.
        sr_phase = PH_IDLE;
        o.status = ST_BUS_ERROR;
      end else begin
        if (!r.id_bit && !r.inv_bit) begin
          // Devices disagree here. At the branch taken last time we now go
          // the one way, past it we start with zero, before it we repeat the
          // previous choice. Every zero taken is a branch left to revisit.
          if (sr_pos == sr_last) begin
            dir = 1'b1;
          end else if (sr_pos > sr_last) begin
            dir = 1'b0;
            sr_last_zero = sr_pos;
          end else begin
            dir = sr_code[6'(sr_pos)];
            if (!dir) begin
              sr_last_zero = sr_pos;
            end
          end
        end else begin
          dir = r.id_bit;
        end
        sr_code[6'(sr_pos)] = dir;
        sr_crc = crc8_shift(sr_crc, dir);
        sr_pos = sr_pos + 1;
        o.send_bit = dir;
        if (sr_pos < CODE_BITS) begin
          o.status = ST_DIRECTION;
        end else if (sr_crc != '0) begin
          sr_phase = PH_IDLE;
          o.status = ST_CRC_ERROR;
        end else begin
          // A limit of zero behaves like one, since the count is at least one here.
          sr_found = sr_found + 8'd1;
          sr_last = sr_last_zero;
          done = (sr_last < 0) || (sr_found >= sr_limit);
          sr_phase = done ? PH_IDLE : PH_READY;
          o.status = ST_FOUND;
          o.rom_code = sr_code;
          o.search_finished = done;
        end
      end
    end
    o.device_number = sr_found;
    return o;
  endfunction

  // Gap length for either side: mostly none, often a few cycles, now and then long.
  function automatic int idle_len(input bit calm);
    int r;
    r = int'($urandom_range(0, 99));
    if (calm || r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(8, 30));
  endfunction

  // Populates a fresh bus. Devices share a random-length prefix with a common
  // base so that discrepancies show up deep in the code, not only at bit zero.
  // Now and then a device carries a corrupted code so a pass ends in a CRC error.
  function automatic void build_bus();
    logic [63:0]      base;
    logic [63:0]      fresh;
    logic [63:0]      keep;
    logic [63:0]      word;
    logic [CRC_W-1:0] c;
    logic [5:0]       flip;
    int               r;
    int               share;
    r = int'($urandom_range(0, 99));
    if (r < 10) begin
      dev_count = 0;
    end else if (r < 88) begin
      dev_count = int'($urandom_range(1, 4));
    end else begin
      dev_count = int'($urandom_range(5, MAX_BUS_DEVICES));
    end
    base = {$urandom, $urandom};
    for (int i = 0; i < dev_count; i++) begin
      share = int'($urandom_range(0, 55));
      keep = (64'd1 << share) - 64'd1;
      fresh = {$urandom, $urandom};
      word = (base & keep) | (fresh & ~keep);
      c = '0;
      for (int b = 0; b < 56; b++) begin
        c = crc8_shift(c, word[b]);
      end
      dev_code[i] = {c, word[55:0]};
      if ($urandom_range(0, 19) == 0) begin
        flip = 6'($urandom_range(0, 63));
        dev_code[i][flip] = ~dev_code[i][flip];
      end
    end
    alive = '1;
  endfunction

  // Wired-AND read of one search slot: the true bit reads low if any live
  // device holds a zero, the complement reads low if any holds a one.
  function automatic logic [1:0] bus_pair(input int at);
    logic id_b;
    logic inv_b;
    id_b = 1'b1;
    inv_b = 1'b1;
    for (int i = 0; i < dev_count; i++) begin
      if (alive[i]) begin
        id_b = id_b & dev_code[i][6'(at)];
        inv_b = inv_b & ~dev_code[i][6'(at)];
      end
    end
    return {id_b, inv_b};
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one request, starting at a falling edge, and returns once it has
  // been taken. The prediction is made right at the accepting edge; a typed-in
  // expectation, when given, replaces it in the queue.
  task automatic push_item(input owrs_req_t r, input bit typed, input owrs_rsp_t want,
                           output owrs_rsp_t got);
    int g;
    g = idle_len(tx_calm);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do begin
      @(posedge clk);
    end while (in_stall);
    got = search_step(r);
    pending_rsp.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // The sender goes quiet until every owed response has been collected.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Changes the device limit with the engine idle. Every request gets a
  // response, so once the queue is empty nothing is left in flight.
  task automatic write_limit(input logic [CNT_W-1:0] v);
    drain();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    sr_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Picks the next request from where the search stands: a begin when idle
  // (with a new bus behind it), a reset outcome when ready, bus-driven bit pairs
  // inside a pass. A few percent of requests are random noise, which also
  // brings in the unused request code and broken sequences.
  task automatic next_random_item();
    owrs_req_t  r;
    owrs_rsp_t  got;
    logic [4:0] raw;
    int         at;
    raw = 5'($urandom);
    r = raw;
    at = sr_pos;
    if ($urandom_range(0, 99) >= 4) begin
      case (sr_phase)
        PH_IDLE: begin
          build_bus();
          r.req_type = REQ_BEGIN;
        end
        PH_READY: begin
          // Once something was found, sometimes let the bus fall silent early.
          r.req_type = REQ_RESET;
          r.presence = (dev_count > 0) && !(sr_found != '0 && $urandom_range(0, 7) == 0);
        end
        default: begin
          r.req_type = REQ_BIT;
          if ($urandom_range(0, 99) >= 2) begin
            {r.id_bit, r.inv_bit} = bus_pair(at);
          end
        end
      endcase
    end
    push_item(r, 1'b0, '0, got);
    if (r.req_type == REQ_RESET && got.status == ST_ACCEPTED && !got.search_finished) begin
      alive = '1;
    end else if (r.req_type == REQ_BIT && (got.status == ST_DIRECTION ||
                 got.status == ST_FOUND || got.status == ST_CRC_ERROR)) begin
      for (int i = 0; i < dev_count; i++) begin
        if (dev_code[i][6'(at)] != got.send_bit) begin
          alive[i] = 1'b0;
        end
      end
    end
  endtask

  // Bring-up table. Rows with the flag set carry their answer, which needs no
  // model to see; the others go through the predictor. No device is found in
  // this part, so the typed answers all carry a zero count and no code.
  typedef struct packed {
    owrs_req_t req;
    logic      typed;
    status_t   st;
  } step_row_t;

  step_row_t bringup [0:21] = '{
    // Nothing but a begin is welcome before the first search.
    {REQ_BIT,    1'b0, 1'b0, 1'b0, 1'b1, ST_OUT_OF_SEQ},
    {REQ_RESET,  1'b1, 1'b0, 1'b0, 1'b1, ST_OUT_OF_SEQ},
    {REQ_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, ST_OUT_OF_SEQ},
    {REQ_BEGIN,  1'b1, 1'b1, 1'b1, 1'b1, ST_ACCEPTED},
    // Ready wants a reset outcome, not a bit; an empty bus ends the search.
    {REQ_BIT,    1'b0, 1'b1, 1'b0, 1'b1, ST_OUT_OF_SEQ},
    {REQ_RESET,  1'b0, 1'b1, 1'b1, 1'b1, ST_NO_PRESENCE},
    {REQ_BIT,    1'b0, 1'b0, 1'b1, 1'b1, ST_OUT_OF_SEQ},
    // A pass that sees a slot with no answer at all.
    {REQ_BEGIN,  1'b0, 1'b0, 1'b0, 1'b1, ST_ACCEPTED},
    {REQ_RESET,  1'b1, 1'b0, 1'b0, 1'b1, ST_ACCEPTED},
    {REQ_RESET,  1'b1, 1'b0, 1'b0, 1'b1, ST_OUT_OF_SEQ},
    {REQ_BIT,    1'b0, 1'b1, 1'b1, 1'b1, ST_BUS_ERROR},
    {REQ_BIT,    1'b0, 1'b0, 1'b0, 1'b1, ST_OUT_OF_SEQ},
    // Discrepancy, then both single-valued slots, then a mid-pass bus error.
    {REQ_BEGIN,  1'b0, 1'b1, 1'b0, 1'b1, ST_ACCEPTED},
    {REQ_RESET,  1'b1, 1'b1, 1'b0, 1'b1, ST_ACCEPTED},
    {REQ_BIT,    1'b1, 1'b0, 1'b0, 1'b0, ST_ACCEPTED},
    {REQ_BIT,    1'b0, 1'b1, 1'b0, 1'b0, ST_ACCEPTED},
    {REQ_BIT,    1'b1, 1'b0, 1'b1, 1'b0, ST_ACCEPTED},
    {REQ_BIT,    1'b0, 1'b1, 1'b1, 1'b1, ST_BUS_ERROR},
    // A begin in the middle of a pass restarts everything.
    {REQ_BEGIN,  1'b1, 1'b0, 1'b1, 1'b1, ST_ACCEPTED},
    {REQ_RESET,  1'b1, 1'b0, 1'b1, 1'b1, ST_ACCEPTED},
    {REQ_BIT,    1'b0, 1'b0, 1'b0, 1'b0, ST_ACCEPTED},
    {REQ_BEGIN,  1'b0, 1'b1, 1'b1, 1'b1, ST_ACCEPTED}
  };

  // Response side: random stalls, plus the one long hold-off, counted here.
  initial begin
    int left;
    int held;
    left = 0;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask && held < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        held++;
      end else if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        left = idle_len(rx_calm);
        out_stall <= (left > 0);
        if (left > 0) begin
          left--;
        end
      end
    end
  end

  // Every response taken is matched against the oldest one owed.
  always @(posedge clk) begin
    owrs_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        flag_mismatch("unrequested response, status", 64'(out_data.status), '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.status !== want.status) begin
          flag_mismatch("status", 64'(out_data.status), 64'(want.status));
        end
        if (out_data.send_bit !== want.send_bit) begin
          flag_mismatch("send_bit", 64'(out_data.send_bit), 64'(want.send_bit));
        end
        if (out_data.rom_code !== want.rom_code) begin
          flag_mismatch("rom_code", out_data.rom_code, want.rom_code);
        end
        if (out_data.device_number !== want.device_number) begin
          flag_mismatch("device_number", 64'(out_data.device_number),
                        64'(want.device_number));
        end
        if (out_data.search_finished !== want.search_finished) begin
          flag_mismatch("search_finished", 64'(out_data.search_finished),
                        64'(want.search_finished));
        end
      end
    end
  end

  initial begin
    owrs_rsp_t        want;
    owrs_rsp_t        got;
    logic [CNT_W-1:0] limits [0:4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sr_code = '0;
    sr_last = -1;
    sr_last_zero = -1;
    sr_pos = 0;
    sr_crc = '0;
    sr_found = '0;
    sr_limit = MAX_DEV_RESET;
    sr_phase = PH_IDLE;
    dev_count = 0;
    alive = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    for (int i = 0; i < 22; i++) begin
      want = '0;
      want.status = bringup[i].st;
      push_item(bringup[i].req, bringup[i].typed, want, got);
    end

    // Random phases. The first runs at the reset limit, then the limit goes to
    // one, to the top of its range, to zero, and to a random value.
    limits[0] = MAX_DEV_RESET;
    limits[1] = 8'd1;
    limits[2] = 8'd255;
    limits[3] = 8'd0;
    limits[4] = 8'($urandom_range(1, 255));
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_limit(limits[ph]);
      end
      // Phase one pushes back to back into a receiver that holds off, so the
      // pipeline fills and the input stalls. Phase three runs with no idling.
      tx_calm = (ph == 1) || (ph == 3);
      rx_calm = (ph == 3);
      if (ph == 1) begin
        hold_ask = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        next_random_item();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog at 4 ms, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/owrs_pkg.sv
src/owrs_step.sv
src/onewire_rom_search.sv
dv/tb_top.sv
